@@ hw/rtl/skt_pkg.sv @@
package skt_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LIST   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     live;
        logic     tail;
    } cell_ctl_t;

endpackage

@@ hw/rtl/skt_cell.sv @@
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                clk,
    input  cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_ge,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [KEY_BITS-1:0] head_key,
    output logic [KEY_BITS-1:0] key,
    output logic                ge,
    output logic                match
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                match_reg;
    logic                match_next;

    // an empty slot counts as greater, so the row is monotone in ge
    always_comb
    begin
        ge         = !ctl.live || (key_reg >= req_key);
        match_next = ctl.live && (key_reg == req_key);
        key_next   = key_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                key_next = key_reg;
            end
            CELL_INSERT:
            begin
                if (ge)
                begin
                    key_next = left_ge ? left_key : req_key;
                end
            end
            CELL_DELETE:
            begin
                if (ge)
                begin
                    key_next = right_key;
                end
            end
            CELL_ROTATE:
            begin
                key_next = ctl.tail ? head_key : right_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
    end

    assign key   = key_reg;
    assign match = match_reg;

endmodule

@@ hw/rtl/sorted_key_table_unit.sv @@
// insert, unused func, and delete or list of an empty table: result strobe registered
// in S_EXEC; any other delete in S_DEL; busy stays high until the result cycle
// list of n keys: n results on consecutive cycles from S_LIST on, as
// the cell row rotates one slot a cycle; the next request may start with the last result
// results leave through output registers; the receiver cannot stall them
// rst_n clears the key count and control; stored keys are not cleared
module sorted_key_table_unit
    import skt_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    localparam int CW      = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic [1:0]          status,
    output logic [KEY_BITS-1:0] entry_key,
    output logic [CW-1:0]       occupancy,
    output logic                last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEL,
        S_LIST
    } state_t;

    state_t              state_reg;
    func_t               func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic                done_reg;
    status_t             status_reg;
    logic [KEY_BITS-1:0] entry_key_reg;
    logic [CW-1:0]       occupancy_reg;
    logic                last_reg;

    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0]    ge_vec;
    logic [DEPTH-1:0]    match_vec;
    cell_ctl_t           ctl [DEPTH];
    cell_op_t            row_op;
    logic                full;
    logic                empty;
    logic                found;
    logic [CW-1:0]       count_m1;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign found    = |match_vec;
    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        row_op = CELL_HOLD;
        unique case (state_reg)
            S_EXEC:
            begin
                if (func_reg == FUNC_INSERT && !full)
                begin
                    row_op = CELL_INSERT;
                end
            end
            S_DEL:
            begin
                if (found)
                begin
                    row_op = CELL_DELETE;
                end
            end
            S_LIST:
            begin
                row_op = CELL_ROTATE;
            end
            default:
            begin
                row_op = CELL_HOLD;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_ge;
            logic [KEY_BITS-1:0] right_key;

            assign ctl[g].op   = row_op;
            assign ctl[g].live = (CW'(g) < count_reg);
            assign ctl[g].tail = (CW'(g) == count_m1);

            if (g == 0)
            begin : g_first
                assign left_key = key_reg;
                assign left_ge  = 1'b0;
            end
            else
            begin : g_inner
                assign left_key = cell_key[g-1];
                assign left_ge  = ge_vec[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_end
                assign right_key = '0;
            end
            else
            begin : g_mid
                assign right_key = cell_key[g+1];
            end

            skt_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl[g]),
                .req_key   (key_reg),
                .left_key  (left_key),
                .left_ge   (left_ge),
                .right_key (right_key),
                .head_key  (cell_key[0]),
                .key       (cell_key[g]),
                .ge        (ge_vec[g]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_INSERT;
            key_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            entry_key_reg <= '0;
            occupancy_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg  <= func_t'(func);
                        key_reg   <= key;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    entry_key_reg <= '0;
                    last_reg      <= 1'b1;
                    occupancy_reg <= count_reg;
                    unique case (func_reg)
                        FUNC_INSERT:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg    <= ST_OK;
                                count_reg     <= count_reg + 1'b1;
                                occupancy_reg <= count_reg + 1'b1;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (empty)
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                // match flags settle this cycle, decide next
                                state_reg <= S_DEL;
                            end
                        end
                        FUNC_LIST:
                        begin
                            if (empty)
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_EMPTY;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_LIST;
                            end
                        end
                        default:
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ST_OK;
                            state_reg  <= S_IDLE;
                        end
                    endcase
                end
                S_DEL:
                begin
                    done_reg      <= 1'b1;
                    entry_key_reg <= '0;
                    last_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (found)
                    begin
                        status_reg    <= ST_OK;
                        count_reg     <= count_m1;
                        occupancy_reg <= count_m1;
                    end
                    else
                    begin
                        status_reg    <= ST_NOT_FOUND;
                        occupancy_reg <= count_reg;
                    end
                end
                S_LIST:
                begin
                    // head of the row leaves, the row rotates by one slot
                    done_reg      <= 1'b1;
                    status_reg    <= ST_OK;
                    entry_key_reg <= cell_key[0];
                    occupancy_reg <= count_reg;
                    last_reg      <= (idx_reg == count_m1);
                    idx_reg       <= idx_reg + 1'b1;
                    if (idx_reg == count_m1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign entry_key = entry_key_reg;
    assign occupancy = occupancy_reg;
    assign last      = last_reg;

endmodule

@@ tb/tb.sv @@
module tb
    import skt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEPTH_DEF;
    localparam int KW          = KEY_BITS_DEF;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_REQS = 320;

    typedef struct {
        func_t         func;
        logic [KW-1:0] key;
    } request_t;

    typedef struct {
        status_t       status;
        logic [KW-1:0] entry_key;
        logic [CW-1:0] occupancy;
        logic          last;
    } reply_t;

    logic          clk   = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [1:0]    func  = FUNC_INSERT;
    logic [KW-1:0] key   = '0;
    logic          busy;
    logic          done;
    logic [1:0]    status;
    logic [KW-1:0] entry_key;
    logic [CW-1:0] occupancy;
    logic          last;

    request_t      request_queue[$];
    reply_t        expected_replies[$];
    logic [KW-1:0] sorted_keys[TABLE_DEPTH];
    int            key_count = 0;
    logic [KW-1:0] gen_keys[$];
    int            accepted_reqs = 0;
    int            mismatches = 0;
    int            quiet_cycles = 0;

    sorted_key_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .key       (key),
        .done      (done),
        .status    (status),
        .entry_key (entry_key),
        .occupancy (occupancy),
        .last      (last)
    );

    always #1 clk = ~clk;

    task automatic push_reply(input status_t st, input logic [KW-1:0] ek, input logic fin);
        reply_t r;
        r.status    = st;
        r.entry_key = ek;
        r.occupancy = CW'(key_count);
        r.last      = fin;
        expected_replies.push_back(r);
    endtask

    // expected replies of one accepted request, updating the table copy
    task automatic apply_to_keys(input func_t f, input logic [KW-1:0] k);
        int pos;
        pos = 0;
        case (f)
            FUNC_INSERT:
            begin
                if (key_count >= TABLE_DEPTH) begin
                    push_reply(ST_FULL, '0, 1'b1);
                end else begin
                    while (pos < key_count && sorted_keys[pos] < k)
                        pos++;
                    for (int i = key_count; i > pos; i--)
                        sorted_keys[i] = sorted_keys[i - 1];
                    sorted_keys[pos] = k;
                    key_count++;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            FUNC_DELETE:
            begin
                if (key_count == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    while (pos < key_count && sorted_keys[pos] != k)
                        pos++;
                    if (pos >= key_count) begin
                        push_reply(ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        for (int i = pos; i + 1 < key_count; i++)
                            sorted_keys[i] = sorted_keys[i + 1];
                        key_count--;
                        push_reply(ST_OK, '0, 1'b1);
                    end
                end
            end
            FUNC_LIST:
            begin
                if (key_count == 0) begin
                    push_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < key_count; i++)
                        push_reply(ST_OK, sorted_keys[i], i + 1 == key_count);
                end
            end
            default:
            begin
                push_reply(ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    // queues a request and tracks which keys the table will hold, so deletes can hit
    task automatic queue_request(input func_t f, input logic [KW-1:0] k);
        request_t rq;
        int       hits[$];
        rq.func = f;
        rq.key  = k;
        request_queue.push_back(rq);
        if (f == FUNC_INSERT && gen_keys.size() < TABLE_DEPTH) begin
            gen_keys.push_back(k);
        end else if (f == FUNC_DELETE) begin
            hits = gen_keys.find_first_index(x) with (x == k);
            if (hits.size() > 0)
                gen_keys.delete(hits[0]);
        end
    endtask

    always @(posedge clk) begin : drive
        request_t rq;
        logic     offer;
        logic     idle_on;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            offer = start;
            if (start && !busy) begin
                rq = request_queue.pop_front();
                apply_to_keys(rq.func, rq.key);
                accepted_reqs++;
                offer = 1'b0;
            end
            // a long stretch in the middle runs with no gaps
            idle_on = !(accepted_reqs >= 120 && accepted_reqs < 200);
            if (!offer && request_queue.size() > 0)
                offer = !(idle_on && $urandom_range(99) < 32);
            start <= offer;
            if (offer) begin
                func <= request_queue[0].func;
                key  <= request_queue[0].key;
            end
        end
    end

    always @(posedge clk) begin : check
        reply_t exp;
        if (rst_n && done) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result: status %0d entry_key %0h", status, entry_key);
                mismatches++;
            end else begin
                exp = expected_replies.pop_front();
                if (status !== exp.status) begin
                    $error("status: expected %0d, actual %0d", exp.status, status);
                    mismatches++;
                end
                if (entry_key !== exp.entry_key) begin
                    $error("entry_key: expected %0h, actual %0h", exp.entry_key, entry_key);
                    mismatches++;
                end
                if (occupancy !== exp.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d", exp.occupancy, occupancy);
                    mismatches++;
                end
                if (last !== exp.last) begin
                    $error("last: expected %0b, actual %0b", exp.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        func_t         f;
        logic [KW-1:0] k;
        int            r;
        int            sel;
        bit            filling;

        // directed: empty table, extremes, ties at the head, absent key
        queue_request(FUNC_LIST, '0);
        queue_request(FUNC_DELETE, 16'h0005);
        queue_request(FUNC_NONE, '1);
        queue_request(FUNC_INSERT, 16'h8000);
        queue_request(FUNC_INSERT, '1);
        queue_request(FUNC_INSERT, '0);
        queue_request(FUNC_INSERT, '0);
        queue_request(FUNC_INSERT, 16'h0001);
        queue_request(FUNC_INSERT, 16'h8000);
        queue_request(FUNC_DELETE, 16'h1234);
        queue_request(FUNC_LIST, '1);
        queue_request(FUNC_DELETE, '0);
        queue_request(FUNC_DELETE, '1);
        queue_request(FUNC_DELETE, 16'h8000);
        queue_request(FUNC_NONE, '0);
        queue_request(FUNC_LIST, '0);

        // random: alternate insert-heavy and delete-heavy phases to hit full and empty
        for (int n = 0; n < RANDOM_REQS; n++) begin
            filling = ((n / 40) % 2) == 0;
            r = $urandom_range(99);
            if (r < 7)
                f = FUNC_LIST;
            else if (r < 10)
                f = FUNC_NONE;
            else if (r < (filling ? 72 : 32))
                f = FUNC_INSERT;
            else
                f = FUNC_DELETE;
            sel = $urandom_range(9);
            if (gen_keys.size() > 0 && (sel < 2 || (f == FUNC_DELETE && sel < 8)))
                k = gen_keys[$urandom_range(gen_keys.size() - 1)];
            else if (sel == 9)
                k = $urandom_range(1) ? '1 : '0;
            else if (sel == 8)
                k = KW'($urandom_range(15));
            else
                k = KW'($urandom_range(16'hFFFF));
            queue_request(f, k);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (request_queue.size() != 0 || start || expected_replies.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
